// ----- design/nms_5x5_peak_marker_defines.svh -----
// Assertion shorthands used by the peak marker RTL.
`ifndef NMS_5X5_PEAK_MARKER_DEFINES_SVH
`define NMS_5X5_PEAK_MARKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NMS_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NMS_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nms5_pkg.sv -----
package nms5_pkg;

    localparam int PIX_W = 8;
    localparam int DIM_W = 9;
    localparam int COORD_W = 8;
    localparam int WIN = 5;
    localparam int LINES = WIN - 1;
    localparam int WIN_PIXELS = WIN * WIN;   // 25 pixels in the window
    localparam int MIN_DIM = WIN;
    localparam int HALF_WIN = WIN / 2;

    localparam int DEF_MAX_WIDTH = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd80;
    localparam logic [DIM_W-1:0] WIDTH_RESET = 9'd176;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd144;
    localparam logic [PIX_W-1:0] MARK_ON = 8'd255;
    localparam logic [PIX_W-1:0] MARK_OFF = 8'd0;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_PEAK_THRESHOLD = 2'd0;
    localparam reg_idx_t REG_FRAME_WIDTH = 2'd1;
    localparam reg_idx_t REG_FRAME_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [LINES-1:0] line_col_t;   // [0] oldest line
    typedef pix_t [WIN-1:0] pix_row_t;
    typedef pix_row_t [WIN-1:0] window_t;   // [line][column], highest index newest

    // What travels with a pixel from the input register to the result register
    typedef struct packed {
        logic produce;
        logic frame_last;
        logic [COORD_W-1:0] centre_row;
        logic [COORD_W-1:0] centre_col;
    } nms5_meta_t;

endpackage

// ----- design/nms_5x5_peak_marker.sv -----
// A pixel taken on s_* waits in the pixel stage; its result then goes to the result
// register, offered on m_*. Throughput: one pixel per clock unless m_* holds off a
// result; the line store's single read and single write per cycle set that rate.
// Reset (aresetn low, synchronous): row/column counters, window and both handshakes
// clear; threshold 80, width 176, height 144. The line store is not cleared.
`include "nms_5x5_peak_marker_defines.svh"

module nms_5x5_peak_marker import nms5_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             aclk,
    input  logic             aresetn,
    // pixel in
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] luma
    // marks out
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,    // [7:0] mark_value, [15:8] centre_row,
                                         // [23:16] centre_col
    output logic             m_tlast,    // frame_last
    // register writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  reg_idx_t         cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CWW = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int CWH = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

    pix_t peak_threshold_reg;
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    logic a_valid_reg;
    nms5_meta_t a_meta_reg;
    nms5_meta_t meta_next;
    pix_t a_px_reg;

    logic m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic m_tlast_reg;

    logic s_accept, a_fire, out_free, is_peak;
    logic [CWW-1:0] w_eff, fw_ext, col_ext, c_ext, c_inc;
    logic [CWH-1:0] h_eff, fh_ext, row_ext, row_pre, r_ext, r_inc;
    logic col_wrap, row_wrap;
    line_col_t lines;
    pix_row_t column;

    // register port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_threshold_reg <= THRESHOLD_RESET;
            frame_width_reg <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PEAK_THRESHOLD: peak_threshold_reg <= cfg_data[PIX_W-1:0];
                REG_FRAME_WIDTH:    frame_width_reg <= cfg_data;
                REG_FRAME_HEIGHT:   frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // geometry clamped to [5, MAX]
    always_comb begin
        fw_ext = CWW'(frame_width_reg);
        fh_ext = CWH'(frame_height_reg);
        priority if (fw_ext < CWW'(MIN_DIM)) w_eff = CWW'(MIN_DIM);
        else if (fw_ext > CWW'(MAX_WIDTH)) w_eff = CWW'(MAX_WIDTH);
        else w_eff = fw_ext;
        priority if (fh_ext < CWH'(MIN_DIM)) h_eff = CWH'(MIN_DIM);
        else if (fh_ext > CWH'(MAX_HEIGHT)) h_eff = CWH'(MAX_HEIGHT);
        else h_eff = fh_ext;
    end

    // position of the incoming pixel; a shrunk geometry wraps before use
    always_comb begin
        col_ext = CWW'(col_count_reg);
        row_ext = CWH'(row_count_reg);
        if (col_ext >= w_eff) begin
            c_ext = '0;
            row_pre = row_ext + CWH'(1);
        end else begin
            c_ext = col_ext;
            row_pre = row_ext;
        end
        r_ext = (row_pre >= h_eff) ? '0 : row_pre;
        c_inc = c_ext + CWW'(1);
        r_inc = r_ext + CWH'(1);
        col_wrap = (c_inc == w_eff);
        row_wrap = (r_inc == h_eff);

        col_count_next = col_wrap ? '0 : c_inc[COL_W-1:0];
        if (!col_wrap) row_count_next = r_ext[ROW_W-1:0];
        else if (row_wrap) row_count_next = '0;
        else row_count_next = r_inc[ROW_W-1:0];

        meta_next.produce = (r_ext >= CWH'(LINES)) && (c_ext >= CWW'(LINES));
        meta_next.frame_last = col_wrap && row_wrap;
        meta_next.centre_row = COORD_W'(r_ext - CWH'(HALF_WIN));
        meta_next.centre_col = COORD_W'(c_ext - CWW'(HALF_WIN));
    end

    // handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign a_fire = a_valid_reg && (!a_meta_reg.produce || out_free);
    assign s_tready = !a_valid_reg || a_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                a_valid_reg <= 1'b1;
            end else if (a_fire) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_meta_reg <= meta_next;
            a_px_reg <= s_tdata;
        end
    end

    nms5_line_buf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_buf (
        .aclk     (aclk),
        .rd_en    (s_accept),
        .rd_addr  (c_ext[COL_W-1:0]),
        .rd_lines (lines),
        .wr_en    (a_fire),
        .wr_pixel (a_px_reg)
    );

    always_comb begin
        for (int l = 0; l < LINES; l++) begin
            column[l] = lines[l];
        end
        column[WIN-1] = a_px_reg;
    end

    nms5_peak_eval u_peak_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (a_fire),
        .column    (column),
        .threshold (peak_threshold_reg),
        .is_peak   (is_peak)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (a_fire && a_meta_reg.produce) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire && a_meta_reg.produce) begin
            m_tdata_reg <= {a_meta_reg.centre_col, a_meta_reg.centre_row,
                            is_peak ? MARK_ON : MARK_OFF};
            m_tlast_reg <= a_meta_reg.frame_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

    `NMS_ASSERT_SAME(a_stall_only_when_full, !s_tready, a_valid_reg,
        "input held off with an empty pixel stage")
    `NMS_ASSERT_NEXT(a_produce_loads_out, a_fire && a_meta_reg.produce, m_tvalid_reg,
        "producing pixel left without a result")
    `NMS_ASSERT_NEXT(a_blocked_holds,
        a_valid_reg && a_meta_reg.produce && m_tvalid_reg && !m_tready,
        a_valid_reg, "pixel dropped while result register blocked")
    `NMS_ASSERT_SAME(a_mark_binary, m_tvalid_reg,
        m_tdata_reg[PIX_W-1:0] == MARK_ON || m_tdata_reg[PIX_W-1:0] == MARK_OFF,
        "mark neither set nor clear")

endmodule

// ----- design/nms5_line_buf.sv -----
module nms5_line_buf import nms5_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output line_col_t                    rd_lines,
    input  logic                         wr_en,
    input  pix_t                         wr_pixel
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // one word per column, four lines deep
    line_col_t mem [MAX_WIDTH];
    line_col_t rd_data_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
        // lines move up by one, the new pixel becomes the newest line
        if (wr_en) begin
            mem[addr_reg] <= {wr_pixel, rd_data_reg[LINES-1:1]};
        end
    end

    assign rd_lines = rd_data_reg;

endmodule

// ----- design/nms5_peak_eval.sv -----
module nms5_peak_eval import nms5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     shift_en,
    input  pix_row_t column,
    input  pix_t     threshold,
    output logic     is_peak
);

    window_t win_reg;
    window_t win_next;
    pix_t centre;
    logic all_le;

    always_comb begin
        for (int l = 0; l < WIN; l++) begin
            for (int k = 0; k < WIN - 1; k++) begin
                win_next[l][k] = win_reg[l][k+1];
            end
            win_next[l][WIN-1] = column[l];
        end
    end

    // ties with the centre still count as a maximum
    always_comb begin
        centre = win_next[HALF_WIN][HALF_WIN];
        all_le = 1'b1;
        for (int l = 0; l < WIN; l++) begin
            for (int k = 0; k < WIN; k++) begin
                if (win_next[l][k] > centre) begin
                    all_le = 1'b0;
                end
            end
        end
    end

    assign is_peak = all_le && (centre > threshold);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (shift_en) begin
            win_reg <= win_next;
        end
    end

endmodule
